FILE: rtl/fpa_pkg.sv
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam logic [31:0] STEP_ONE = 32'd1;

  typedef enum logic [4:0] {
    FN_ADD        = 5'd0,
    FN_SUB        = 5'd1,
    FN_MUL        = 5'd2,
    FN_DIV        = 5'd3,
    FN_GT         = 5'd4,
    FN_LT         = 5'd5,
    FN_GE         = 5'd6,
    FN_LE         = 5'd7,
    FN_EQ         = 5'd8,
    FN_NE         = 5'd9,
    FN_MIN        = 5'd10,
    FN_MAX        = 5'd11,
    FN_INC        = 5'd12,
    FN_DEC        = 5'd13,
    FN_TO_INT     = 5'd14,
    FN_FROM_INT   = 5'd15,
    FN_TO_FLOAT   = 5'd16,
    FN_FROM_FLOAT = 5'd17
  } func_t;

  typedef struct packed {
    logic [4:0]  func;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } alu_in_t;

  typedef struct packed {
    logic [31:0] result_word;
    logic        compare_true;
    logic        error_flag;
  } alu_out_t;

endpackage

FILE: rtl/fixed_point_alu_top.sv
// Fixed-point ALU, one operation per transfer, all operations share one pipeline.
// Pipeline depth is set by the one-bit-per-stage divider.
// Throughput: one transfer per cycle; a stalled output holds the whole pipeline.
// Reset clears all valid bits; data registers are not reset.
module fixed_point_alu_top import fpa_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  alu_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output alu_out_t out_data
);

  localparam int DW = 32 + FRACTION_BITS;
  localparam int LD = DW + 2;
  localparam int NS = LD + 2;

  logic          adv;
  logic [NS-1:0] vld;
  logic [4:0]    s0_func;
  logic [31:0]   s0_a;
  logic [31:0]   s0_b;
  logic [4:0]    fln [1:LD];
  alu_out_t      res_line [0:LD-4];
  alu_out_t      alu_res;
  alu_out_t      cvt_res;
  alu_out_t      div_res;

  assign adv       = !vld[NS-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_func <= in_data.func;
      s0_a    <= in_data.operand_a;
      s0_b    <= in_data.operand_b;
      fln[1]  <= s0_func;
      for (int k = 2; k <= LD; k++) begin
        fln[k] <= fln[k-1];
      end
      res_line[0] <= (fln[3] == FN_TO_FLOAT || fln[3] == FN_FROM_FLOAT) ? cvt_res : alu_res;
      for (int k = 1; k <= LD - 4; k++) begin
        res_line[k] <= res_line[k-1];
      end
      out_data <= (fln[LD] == FN_DIV) ? div_res : res_line[LD-4];
    end
  end

  fpa_alu #(.FRACTION_BITS(FRACTION_BITS)) u_alu (
    .clk  (clk),
    .en   (adv),
    .func (s0_func),
    .a    (s0_a),
    .b    (s0_b),
    .res  (alu_res)
  );

  fpa_cvt #(.FRACTION_BITS(FRACTION_BITS)) u_cvt (
    .clk  (clk),
    .en   (adv),
    .func (s0_func),
    .a    (s0_a),
    .res  (cvt_res)
  );

  fpa_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk (clk),
    .en  (adv),
    .a   (s0_a),
    .b   (s0_b),
    .res (div_res)
  );

  a_err_zero_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error_flag |-> out_data.result_word == 32'd0)
    else $error("error transfer with nonzero word");

  a_cmp_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.compare_true |-> out_data.result_word == 32'd0 && !out_data.error_flag)
    else $error("comparison transfer carries word or error");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while output stalled");

endmodule

FILE: rtl/fpa_alu.sv
module fpa_alu import fpa_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [4:0]  func,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output alu_out_t    res
);

  localparam logic [31:0] FMASK32 = (32'd1 << FRACTION_BITS) - 32'd1;
  localparam logic [63:0] FMASK64 = (64'd1 << FRACTION_BITS) - 64'd1;

  logic               [4:0]  f1;
  logic signed        [63:0] prod1;
  logic               [31:0] sw1;
  logic                      c1;
  logic               [31:0] sw;
  logic                      c;
  logic signed        [31:0] sa;
  logic signed        [31:0] sb;
  logic signed        [31:0] ti;
  logic signed        [63:0] pt;
  logic               [31:0] mulw;
  logic               [31:0] w2;
  logic                      c2;
  alu_out_t                  res2;

  assign sa = $signed(a);
  assign sb = $signed(b);
  assign ti = sa >>> FRACTION_BITS;

  always_comb begin
    sw = '0;
    c  = 1'b0;
    case (func)
      FN_ADD:      sw = a + b;
      FN_SUB:      sw = a - b;
      FN_GT:       c = sa > sb;
      FN_LT:       c = sa < sb;
      FN_GE:       c = sa >= sb;
      FN_LE:       c = sa <= sb;
      FN_EQ:       c = a == b;
      FN_NE:       c = a != b;
      FN_MIN:      sw = (sa < sb) ? a : b;
      FN_MAX:      sw = (sa > sb) ? a : b;
      FN_INC:      sw = a + STEP_ONE;
      FN_DEC:      sw = a - STEP_ONE;
      FN_TO_INT:   sw = $unsigned(ti) + {31'd0, a[31] && ((a & FMASK32) != 32'd0)};
      FN_FROM_INT: sw = a << FRACTION_BITS;
      default:     sw = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1    <= func;
      prod1 <= sa * sb;
      sw1   <= sw;
      c1    <= c;
    end
  end

  assign pt   = prod1 >>> FRACTION_BITS;
  assign mulw = pt[31:0] + {31'd0, prod1[63] && ((prod1 & FMASK64) != 64'd0)};
  assign w2   = (f1 == FN_MUL) ? mulw : sw1;
  assign c2   = c1;

  always_ff @(posedge clk) begin
    if (en) begin
      res2.result_word  <= w2;
      res2.compare_true <= c2;
      res2.error_flag   <= 1'b0;
      res               <= res2;
    end
  end

endmodule

FILE: rtl/fpa_cvt.sv
module fpa_cvt import fpa_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [4:0]  func,
  input  logic [31:0] a,
  output alu_out_t    res
);

  logic [4:0]        f1;
  logic [4:0]        f2;
  logic              t_sgn1;
  logic [31:0]       t_mag1;
  logic              t_zero1;
  logic              f_sgn1;
  logic              f_nan1;
  logic              f_inf1;
  logic signed [9:0] f_k1;
  logic [23:0]       f_sig1;
  logic [7:0]        eeff;
  logic              t_sgn2;
  logic [31:0]       t_mag2;
  logic              t_zero2;
  logic [4:0]        t_lz2;
  logic [4:0]        lz;
  logic              f_sgn2;
  logic              f_nan2;
  logic              f_sat2;
  logic [31:0]       f_mag2;
  logic              sat;
  logic [31:0]       mag;
  logic [9:0]        shr;
  logic [24:0]       shv;
  logic [31:0]       n;
  logic [7:0]        e8;
  logic              rnd;
  logic [30:0]       body;
  logic [31:0]       tf_word;
  logic [31:0]       ff_word;

  assign eeff = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];

  always_ff @(posedge clk) begin
    if (en) begin
      f1      <= func;
      t_sgn1  <= a[31];
      t_mag1  <= a[31] ? (32'd0 - a) : a;
      t_zero1 <= a == 32'd0;
      f_sgn1  <= a[31];
      f_nan1  <= (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
      f_inf1  <= (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
      f_k1    <= $signed({2'b00, eeff}) - 10'sd150 + $signed(10'(FRACTION_BITS));
      f_sig1  <= {a[30:23] != 8'd0, a[22:0]};
    end
  end

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (t_mag1[i]) lz = 5'(31 - i);
    end
  end

  always_comb begin
    sat = 1'b0;
    mag = '0;
    shr = '0;
    shv = '0;
    if (f_inf1 || f_k1 >= 10'sd8) begin
      sat = 1'b1;
    end else if (f_k1 >= 10'sd0) begin
      mag = {8'd0, f_sig1} << f_k1[2:0];
    end else begin
      shr = 10'd0 - $unsigned(f_k1);
      if (shr <= 10'd25) begin
        shv = {f_sig1, 1'b0} >> shr[4:0];
        mag = {8'd0, shv[24:1]} + {31'd0, shv[0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f2      <= f1;
      t_sgn2  <= t_sgn1;
      t_mag2  <= t_mag1;
      t_zero2 <= t_zero1;
      t_lz2   <= lz;
      f_sgn2  <= f_sgn1;
      f_nan2  <= f_nan1;
      f_sat2  <= sat;
      f_mag2  <= mag;
    end
  end

  assign n       = t_mag2 << t_lz2;
  assign e8      = 8'(9'd158 - {4'd0, t_lz2} - 9'(FRACTION_BITS));
  assign rnd     = n[7] && ((n[6:0] != 7'd0) || n[8]);
  assign body    = {e8, n[30:8]} + {30'd0, rnd};
  assign tf_word = t_zero2 ? 32'd0 : {t_sgn2, body};

  always_comb begin
    if (f_nan2) begin
      ff_word = 32'd0;
    end else if (!f_sgn2 && (f_sat2 || f_mag2 > 32'h7FFF_FFFF)) begin
      ff_word = 32'h7FFF_FFFF;
    end else if (f_sgn2 && (f_sat2 || f_mag2 > 32'h8000_0000)) begin
      ff_word = 32'h8000_0000;
    end else begin
      ff_word = f_sgn2 ? (32'd0 - f_mag2) : f_mag2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.result_word  <= (f2 == FN_TO_FLOAT) ? tf_word : ff_word;
      res.compare_true <= 1'b0;
      res.error_flag   <= (f2 == FN_FROM_FLOAT) && f_nan2;
    end
  end

endmodule

FILE: rtl/fpa_div.sv
module fpa_div import fpa_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output alu_out_t    res
);

  localparam int DW = 32 + FRACTION_BITS;

  logic [31:0]   rem_s [0:DW];
  logic [31:0]   quo_s [0:DW];
  logic [DW-1:0] dvd_s [0:DW];
  logic [31:0]   dsr_s [0:DW];
  logic          neg_s [0:DW];
  logic          bz_s  [0:DW];
  logic [31:0]   amag;
  logic [31:0]   bmag;

  assign amag = a[31] ? (32'd0 - a) : a;
  assign bmag = b[31] ? (32'd0 - b) : b;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= '0;
      quo_s[0] <= '0;
      dvd_s[0] <= {amag, {FRACTION_BITS{1'b0}}};
      dsr_s[0] <= bmag;
      neg_s[0] <= a[31] ^ b[31];
      bz_s[0]  <= b == 32'd0;
    end
  end

  for (genvar i = 0; i < DW; i++) begin : g_step
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign trial = {rem_s[i], dvd_s[i][DW-1]};
    assign diff  = trial - {1'b0, dsr_s[i]};
    assign ge    = trial >= {1'b0, dsr_s[i]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[i+1] <= ge ? diff[31:0] : trial[31:0];
        quo_s[i+1] <= {quo_s[i][30:0], ge};
        dvd_s[i+1] <= dvd_s[i] << 1;
        dsr_s[i+1] <= dsr_s[i];
        neg_s[i+1] <= neg_s[i];
        bz_s[i+1]  <= bz_s[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.result_word  <= bz_s[DW] ? 32'd0 :
                          (neg_s[DW] ? (32'd0 - quo_s[DW]) : quo_s[DW]);
      res.compare_true <= 1'b0;
      res.error_flag   <= bz_s[DW];
    end
  end

endmodule

FILE: verif/fixed_point_alu_checker.sv
module fixed_point_alu_checker import fpa_pkg::*; #(
  parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_ready,
  input  alu_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  alu_out_t out_data,
  output int       fail_count,
  output int       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  alu_out_t awaited_results[$];

  function automatic logic [31:0] fixed_to_single(logic signed [31:0] raw);
    logic [32:0] mag;
    logic [32:0] mant;
    logic [32:0] rem;
    logic [32:0] half;
    logic [7:0]  bexp;
    int          msb;
    int          sh;
    if (raw == 0) return 32'd0;
    mag = raw[31] ? 33'(-$signed({raw[31], raw})) : {1'b0, raw};
    msb = 0;
    for (int i = 0; i < 33; i++) if (mag[i]) msb = i;
    bexp = 8'(127 + msb - FRACTION_BITS);
    if (msb <= 23) begin
      mant = mag << (23 - msb);
    end else begin
      sh = msb - 23;
      mant = mag >> sh;
      rem = mag & ((33'd1 << sh) - 33'd1);
      half = 33'd1 << (sh - 1);
      if (rem > half || (rem == half && mant[0])) mant = mant + 33'd1;
      if (mant[24]) begin
        mant = mant >> 1;
        bexp = bexp + 8'd1;
      end
    end
    return {raw[31], bexp, mant[22:0]};
  endfunction

  function automatic logic [32:0] single_to_fixed(logic [31:0] bits);
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    int          s;
    int          sh;
    if (bits[30:23] == 8'hFF && bits[22:0] != 0) return {1'b1, 32'd0};
    if (bits[30:23] == 8'hFF) return {1'b0, bits[31] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    if (bits[30:23] == 0) begin
      m = {41'd0, bits[22:0]};
      s = -149 + FRACTION_BITS;
    end else begin
      m = {40'd0, 1'b1, bits[22:0]};
      s = int'(bits[30:23]) - 150 + FRACTION_BITS;
    end
    if (m == 0) return 33'd0;
    if (s >= 0) begin
      q = (s > 39) ? 64'hFFFF_FFFF_FFFF : (m << s);
    end else begin
      sh = -s;
      if (sh >= 26) begin
        q = 0;
      end else begin
        q = m >> sh;
        rem = m & ((64'd1 << sh) - 64'd1);
        if (rem >= (64'd1 << (sh - 1))) q = q + 64'd1;
      end
    end
    if (!bits[31]) begin
      if (q > 64'h7FFF_FFFF) return {1'b0, 32'h7FFF_FFFF};
      return {1'b0, q[31:0]};
    end
    if (q > 64'h8000_0000) return {1'b0, 32'h8000_0000};
    return {1'b0, 32'(-q)};
  endfunction

  function automatic alu_out_t compute_alu(alu_in_t x);
    alu_out_t          r;
    longint            a;
    longint            b;
    longint            scale;
    logic [32:0]       conv;
    a = longint'($signed(x.operand_a));
    b = longint'($signed(x.operand_b));
    scale = longint'(1) << FRACTION_BITS;
    r = '0;
    case (x.func)
      FN_ADD:        r.result_word = 32'(a + b);
      FN_SUB:        r.result_word = 32'(a - b);
      FN_MUL:        r.result_word = 32'((a * b) / scale);
      FN_DIV: begin
        if (b == 0) r.error_flag = 1'b1;
        else r.result_word = 32'((a * scale) / b);
      end
      FN_GT:         r.compare_true = a > b;
      FN_LT:         r.compare_true = a < b;
      FN_GE:         r.compare_true = a >= b;
      FN_LE:         r.compare_true = a <= b;
      FN_EQ:         r.compare_true = a == b;
      FN_NE:         r.compare_true = a != b;
      FN_MIN:        r.result_word = 32'((a < b) ? a : b);
      FN_MAX:        r.result_word = 32'((a > b) ? a : b);
      FN_INC:        r.result_word = 32'(a + longint'(STEP_ONE));
      FN_DEC:        r.result_word = 32'(a - longint'(STEP_ONE));
      FN_TO_INT:     r.result_word = 32'(a / scale);
      FN_FROM_INT:   r.result_word = x.operand_a << FRACTION_BITS;
      FN_TO_FLOAT:   r.result_word = fixed_to_single(x.operand_a);
      FN_FROM_FLOAT: begin
        conv = single_to_fixed(x.operand_a);
        r.result_word = conv[31:0];
        r.error_flag = conv[32];
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending = awaited_results.size();

  always @(posedge clk) begin
    alu_out_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) awaited_results.push_back(compute_alu(in_data));
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %h", out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (want !== out_data) begin
            if (fail_count < 10)
              $display("mismatch: expected word %h cmp %b err %b, got word %h cmp %b err %b",
                       want.result_word, want.compare_true, want.error_flag,
                       out_data.result_word, out_data.compare_true, out_data.error_flag);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: verif/tb_fixed_point_alu_top.sv
module tb_fixed_point_alu_top import fpa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  alu_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  alu_out_t out_data;
  int       fail_count;
  int       pending;
  int       cycles = 0;
  logic     calm = 1'b0;

  always #6 clk = ~clk;

  fixed_point_alu_top u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  fixed_point_alu_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_op(logic [4:0] fn, logic [31:0] a, logic [31:0] b);
    int   gap;
    logic rdy;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{func: fn, operand_a: a, operand_b: b};
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 1024)) - 512);
      3: return 32'd0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_single();
    logic [31:0] f;
    f = $urandom();
    if ($urandom_range(0, 3) != 0) f[30:23] = 8'($urandom_range(100, 160));
    if ($urandom_range(0, 15) == 0) f[22:0] = 23'h40_0000;
    return f;
  endfunction

  always begin
    int   stall;
    logic took;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  initial begin
    logic [4:0] fn;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int f = FN_ADD; f <= FN_FROM_FLOAT; f++)
      send_op(5'(f), 32'h8000_0000, 32'h7FFF_FFFF);
    send_op(FN_DIV, 32'h0000_0300, 32'd0);
    send_op(FN_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(FN_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(FN_FROM_FLOAT, 32'h7FC0_0001, 32'd0);
    send_op(FN_FROM_FLOAT, 32'hFF80_0000, 32'd0);
    send_op(FN_FROM_FLOAT, 32'h3F00_0000, 32'd0);
    send_op(FN_TO_FLOAT, 32'h7FFF_FFFF, 32'd0);
    send_op(5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 1650; i++) begin
      if (i % 150 == 0) calm <= ($urandom_range(0, 3) == 0);
      fn = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31)) : 5'($urandom_range(0, 17));
      if (fn == FN_FROM_FLOAT) send_op(fn, pick_single(), $urandom());
      else send_op(fn, pick_word(), pick_word());
    end
    in_valid <= 1'b0;
    calm <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/fpa_pkg.sv
rtl/fpa_alu.sv
rtl/fpa_cvt.sv
rtl/fpa_div.sv
rtl/fixed_point_alu_top.sv
verif/fixed_point_alu_checker.sv
verif/tb_fixed_point_alu_top.sv
